// File: sv/i2r_pkg.sv
// Shared types, symbol codes and digit helpers for the Roman numeral converter.
package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int DIGIT_W  = 4;
    localparam int TH_W     = 2;
    localparam int POS_W    = 2;
    localparam int LEN_W    = 3;

    localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;

    typedef enum logic [1:0] {
        PLACE_TH,
        PLACE_HU,
        PLACE_TE,
        PLACE_UN
    } place_t;

    // Decimal digits of one number; thousands already forced to zero above three.
    typedef struct packed {
        logic [TH_W-1:0]    th;
        logic [DIGIT_W-1:0] hu;
        logic [DIGIT_W-1:0] te;
        logic [DIGIT_W-1:0] un;
    } digits_t;

    // Number of characters one digit writes at its place.
    function automatic logic [LEN_W-1:0] digit_len(input place_t pl, input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        n = '0;
        if (pl == PLACE_TH) begin
            n = (d <= 4'd3) ? d[LEN_W-1:0] : '0;
        end else begin
            unique case (d) inside
                4'd1, 4'd2, 4'd3: n = d[LEN_W-1:0];
                4'd4, 4'd9:       n = 3'd2;
                4'd5:             n = 3'd1;
                4'd6, 4'd7, 4'd8: n = 3'(d - 4'd4);
                default:          n = '0;
            endcase
        end
        return n;
    endfunction

    // Character at position pos of a digit's pattern.
    function automatic logic [SYMBOL_W-1:0] char_at(input place_t pl,
                                                    input logic [DIGIT_W-1:0] d,
                                                    input logic [POS_W-1:0] pos);
        logic [SYMBOL_W-1:0] one;
        logic [SYMBOL_W-1:0] five;
        logic [SYMBOL_W-1:0] ten;
        logic [SYMBOL_W-1:0] c;
        unique case (pl)
            PLACE_TH: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
            PLACE_HU: begin one = SYM_C; five = SYM_D; ten = SYM_M; end
            PLACE_TE: begin one = SYM_X; five = SYM_L; ten = SYM_C; end
            default:  begin one = SYM_I; five = SYM_V; ten = SYM_X; end
        endcase
        c = one;
        if (pl != PLACE_TH) begin
            unique case (d) inside
                4'd4:             c = (pos == '0) ? one : five;
                4'd9:             c = (pos == '0) ? one : ten;
                4'd5, 4'd6, 4'd7, 4'd8: c = (pos == '0) ? five : one;
                default:          c = one;
            endcase
        end
        return c;
    endfunction

endpackage

// File: sv/i2r_front.sv
// Front end: accept a number, split it into decimal digits, drop numbers with no characters.
module i2r_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2r_pkg::VALUE_W-1:0]   s_value,
    input  logic                          q_full,
    output logic                          q_push,
    output i2r_pkg::digits_t              q_entry
);

    logic [2:0]                      th_raw;
    logic [i2r_pkg::VALUE_W-1:0]     th_sub;
    logic [9:0]                      rem1;
    logic [i2r_pkg::DIGIT_W-1:0]     hu;
    logic [9:0]                      hu_sub;
    logic [6:0]                      rem2;
    logic [i2r_pkg::DIGIT_W-1:0]     te;
    logic [6:0]                      te_sub;
    logic [i2r_pkg::DIGIT_W-1:0]     un;
    logic [i2r_pkg::TH_W-1:0]        th;
    logic                            has_chars;

    always_comb begin
        th_raw = 3'd0;
        for (int k = 1; k < 5; k++) begin
            if (s_value >= 12'(k * 1000)) th_raw = 3'(k);
        end
        unique case (th_raw)
            3'd1:    th_sub = 12'd1000;
            3'd2:    th_sub = 12'd2000;
            3'd3:    th_sub = 12'd3000;
            3'd4:    th_sub = 12'd4000;
            default: th_sub = 12'd0;
        endcase
        rem1 = 10'(s_value - th_sub);

        hu     = '0;
        hu_sub = '0;
        for (int k = 1; k < 10; k++) begin
            if (rem1 >= 10'(k * 100)) begin
                hu     = 4'(k);
                hu_sub = 10'(k * 100);
            end
        end
        rem2 = 7'(rem1 - hu_sub);

        te     = '0;
        te_sub = '0;
        for (int k = 1; k < 10; k++) begin
            if (rem2 >= 7'(k * 10)) begin
                te     = 4'(k);
                te_sub = 7'(k * 10);
            end
        end
        un = 4'(rem2 - te_sub);

        // thousands above three write nothing
        th = (th_raw <= 3'd3) ? th_raw[i2r_pkg::TH_W-1:0] : '0;
        has_chars = (th != '0) || (hu != '0) || (te != '0) || (un != '0);
    end

    assign s_ready    = !q_full;
    assign q_push     = s_valid && s_ready && has_chars;
    assign q_entry.th = th;
    assign q_entry.hu = hu;
    assign q_entry.te = te;
    assign q_entry.un = un;

endmodule

// File: sv/i2r_queue.sv
// Short FIFO of digit sets between the front end and the serializer.
module i2r_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  i2r_pkg::digits_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output i2r_pkg::digits_t  head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2r_pkg::digits_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign q_valid    = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full)
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

// File: sv/i2r_back.sv
// Back end: walk the digit places and emit one numeral character per cycle while m_ready is high.
module i2r_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  i2r_pkg::digits_t               head_entry,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [i2r_pkg::SYMBOL_W-1:0]   m_symbol,
    output logic                           m_last
);

    logic                            active_reg, active_next;
    i2r_pkg::digits_t                dig_reg, dig_next;
    i2r_pkg::place_t                 place_reg, place_next;
    logic [i2r_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                            m_valid_reg, m_valid_next;
    logic [i2r_pkg::SYMBOL_W-1:0]    m_symbol_reg, m_symbol_next;
    logic                            m_last_reg, m_last_next;

    logic [i2r_pkg::DIGIT_W-1:0]     cur_d;
    logic [i2r_pkg::LEN_W-1:0]       cur_len;
    logic [3:1]                      nz;
    logic [2:0]                      head_nz;
    logic                            has_next;
    i2r_pkg::place_t                 next_place;
    i2r_pkg::place_t                 head_place;
    logic                            pos_end;
    logic                            advance;
    logic                            emit_last;

    always_comb begin
        unique case (place_reg)
            i2r_pkg::PLACE_TH: cur_d = {2'b00, dig_reg.th};
            i2r_pkg::PLACE_HU: cur_d = dig_reg.hu;
            i2r_pkg::PLACE_TE: cur_d = dig_reg.te;
            default:           cur_d = dig_reg.un;
        endcase
        cur_len = i2r_pkg::digit_len(place_reg, cur_d);

        nz[1] = (i2r_pkg::digit_len(i2r_pkg::PLACE_HU, dig_reg.hu) != '0);
        nz[2] = (i2r_pkg::digit_len(i2r_pkg::PLACE_TE, dig_reg.te) != '0);
        nz[3] = (i2r_pkg::digit_len(i2r_pkg::PLACE_UN, dig_reg.un) != '0);

        head_nz[0] = (head_entry.th != '0);
        head_nz[1] = (i2r_pkg::digit_len(i2r_pkg::PLACE_HU, head_entry.hu) != '0);
        head_nz[2] = (i2r_pkg::digit_len(i2r_pkg::PLACE_TE, head_entry.te) != '0);

        // first later place that writes anything
        has_next   = 1'b0;
        next_place = place_reg;
        for (int p = 3; p > 0; p--) begin
            if (nz[p] && (2'(p) > place_reg)) begin
                has_next   = 1'b1;
                next_place = i2r_pkg::place_t'(2'(p));
            end
        end

        head_place = i2r_pkg::PLACE_UN;
        for (int p = 2; p >= 0; p--) begin
            if (head_nz[p]) head_place = i2r_pkg::place_t'(2'(p));
        end

        pos_end   = (3'(pos_reg) + 3'd1 >= cur_len);
        advance   = active_reg && (!m_valid_reg || m_ready);
        emit_last = pos_end && !has_next;
        q_pop     = q_valid && (!active_reg || (advance && emit_last));

        active_next   = active_reg;
        dig_next      = dig_reg;
        place_next    = place_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (advance) begin
            m_valid_next  = 1'b1;
            m_symbol_next = i2r_pkg::char_at(place_reg, cur_d, pos_reg);
            m_last_next   = emit_last;
            if (!pos_end) begin
                pos_next = i2r_pkg::POS_W'(pos_reg + 1'b1);
            end else if (has_next) begin
                place_next = next_place;
                pos_next   = '0;
            end else begin
                active_next = 1'b0;
            end
        end

        // load the next number as soon as the current one runs out
        if (q_pop) begin
            active_next = 1'b1;
            dig_next    = head_entry;
            place_next  = head_place;
            pos_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg      <= dig_next;
        place_reg    <= place_next;
        pos_reg      <= pos_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

`ifndef SYNTHESIS
    a_pos_in_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (3'(pos_reg) < cur_len))
        else $error("serializer position past end of digit");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !advance) |-> !q_pop)
        else $error("entry loaded while current number unfinished");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit_last && !q_pop) |=> !active_reg)
        else $error("serializer still busy after last transfer");
`endif

endmodule

// File: sv/integer_to_roman_numeral.sv
// Integer to Roman numeral converter: digit split front end, queue, character serializer.
// The first character passes through the queue, the serializer's digit registers and its output register.
// Throughput: one character per cycle while m_ready is high; a number writes 1 to 15 characters.
// Queued numbers follow each other with no gap; the serializer's one-character-per-cycle output sets the rate.
// Numbers that write no characters (0, 4000) are dropped in the front end.
// Reset (aresetn low, synchronous) empties the queue and the output register.
module integer_to_roman_numeral #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [i2r_pkg::VALUE_W-1:0]    s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [i2r_pkg::SYMBOL_W-1:0]   m_symbol,
    output logic                           m_last
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    i2r_pkg::digits_t  push_entry;
    i2r_pkg::digits_t  head_entry;

    i2r_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    i2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .head_entry (head_entry)
    );

    i2r_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .head_entry (head_entry),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_symbol   (m_symbol),
        .m_last     (m_last)
    );

endmodule
